/* hdl/rmq_pkg.sv */
// Shared types, widths and helpers for the rotation-matrix to quaternion block.
package rmq_pkg;

    localparam int DW = 32;
    localparam int QW = 31;
    localparam int VW = 35;
    localparam int MW = 34;
    localparam int LW = 6;
    localparam int SW = 64;
    localparam int NW = 62;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 31;
    localparam logic [QW-1:0] ONE_Q30 = QW'(1) << 30;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } t_in;

    typedef struct packed {
        logic [QW-1:0]        qw;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
        logic                 degenerate;
    } t_out;

    typedef struct packed {
        logic [3:0][QW-1:0] u;
        logic [3:0]         neg;
        logic               deg;
    } t_tag;

    typedef struct packed {
        logic [3:0] neg;
        logic       deg;
    } t_side;

    function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int k = 0; k < MW; k++) begin
            if (v[k]) begin
                n = LW'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

/* hdl/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix in Q2.30 to unit quaternion, fully pipelined.
//
// Input: drive i_in with the nine matrix entries and raise start; the
// transaction is taken at any rising edge where start is high and busy is low.
// busy is held low: the pipeline never stalls, so a new matrix may be
// offered on every cycle.
// Output: each result appears on o_res for exactly one cycle, flagged by
// o_valid. One result per input, in input order. The receiver cannot hold
// results off; it must take each one in the cycle it is shown.
// Throughput: one matrix per cycle. Latency is set by the 32-stage square
// root (one root bit per stage) and the 31-stage dividers (one quotient
// bit per stage, four lanes side by side), plus eight stages of input,
// branch selection, normalising shift, squaring, summing and numerator
// forming, and one output stage.
// Reset clears every valid bit at once; transactions in flight are
// dropped and no result is shown until new inputs arrive.
// A radicand of zero or less gives the identity quaternion with
// degenerate set.
module rotation_matrix_to_quaternion (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rmq_pkg::t_in     i_in,
    output logic             o_valid,
    output rmq_pkg::t_out    o_res
);

    localparam int VW = rmq_pkg::VW;
    localparam int MW = rmq_pkg::MW;
    localparam int QW = rmq_pkg::QW;
    localparam int DW = rmq_pkg::DW;
    localparam int NW = rmq_pkg::NW;

    logic [6:0] r_vld;

    rmq_pkg::t_in r_in;

    logic signed [VW-1:0] n_v [4];
    logic                 n_deg;
    logic signed [VW-1:0] r_v [4];
    logic                 r_deg1;

    logic [3:0][MW-1:0]   r_mag;
    logic [MW-1:0]        r_big;
    rmq_pkg::t_side       r_sd2;

    logic [3:0][MW-1:0]   r_mag3;
    logic [rmq_pkg::LW-1:0] r_len;
    rmq_pkg::t_side       r_sd3;

    logic [3:0][QW-1:0]   r_u;
    rmq_pkg::t_side       r_sd4;

    logic [3:0][2*QW-1:0] r_sq;
    logic [3:0][QW-1:0]   r_u5;
    rmq_pkg::t_side       r_sd5;

    logic [rmq_pkg::SW-1:0] r_sum;
    rmq_pkg::t_tag        r_tag6;

    logic                 sq_vld;
    logic [DW-1:0]        sq_root;
    rmq_pkg::t_tag        sq_tag;

    logic                 r_pvld;
    logic [3:0][NW-1:0]   r_num;
    logic [DW-1:0]        r_den;
    rmq_pkg::t_side       r_psd;

    rmq_pkg::t_side       r_dsd [0:rmq_pkg::DIV_STAGES];
    logic [3:0]           dv_vld;
    logic [3:0][QW-1:0]   dv_quo;

    logic                 r_ovld;

    assign busy = 1'b0;

    always_comb begin
        logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
        logic signed [VW-1:0] one, tr, r;
        a00 = VW'(r_in.m00); a01 = VW'(r_in.m01); a02 = VW'(r_in.m02);
        a10 = VW'(r_in.m10); a11 = VW'(r_in.m11); a12 = VW'(r_in.m12);
        a20 = VW'(r_in.m20); a21 = VW'(r_in.m21); a22 = VW'(r_in.m22);
        one = VW'(rmq_pkg::ONE_Q30);
        tr  = a00 + a11 + a22;
        if (tr > 0) begin
            r = one + tr;
            n_v[0] = r;         n_v[1] = a21 - a12;
            n_v[2] = a02 - a20; n_v[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            r = one + a00 - a11 - a22;
            n_v[0] = a21 - a12; n_v[1] = r;
            n_v[2] = a01 + a10; n_v[3] = a02 + a20;
        end else if (a11 > a22) begin
            r = one + a11 - a00 - a22;
            n_v[0] = a02 - a20; n_v[1] = a01 + a10;
            n_v[2] = r;         n_v[3] = a12 + a21;
        end else begin
            r = one + a22 - a00 - a11;
            n_v[0] = a10 - a01; n_v[1] = a02 + a20;
            n_v[2] = a12 + a21; n_v[3] = r;
        end
        n_deg = r <= 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [MW-1:0] m [4];
        logic [MW-1:0] big;
        if (start && !busy) begin
            r_in <= i_in;
        end
        r_v    <= n_v;
        r_deg1 <= n_deg;

        big = '0;
        for (int k = 0; k < 4; k++) begin
            m[k] = r_v[k][VW-1] ? MW'(-r_v[k]) : MW'(r_v[k]);
            if (m[k] > big) begin
                big = m[k];
            end
            r_mag[k]     <= m[k];
            r_sd2.neg[k] <= r_v[k][VW-1];
        end
        r_big     <= big;
        r_sd2.deg <= r_deg1;

        r_mag3 <= r_mag;
        r_len  <= rmq_pkg::bit_len(r_big);
        r_sd3  <= r_sd2;

        for (int k = 0; k < 4; k++) begin
            if (r_len > rmq_pkg::LW'(QW)) begin
                r_u[k] <= QW'(r_mag3[k] >> (r_len - rmq_pkg::LW'(QW)));
            end else begin
                r_u[k] <= QW'(r_mag3[k] << (rmq_pkg::LW'(QW) - r_len));
            end
        end
        r_sd4 <= r_sd3;

        for (int k = 0; k < 4; k++) begin
            r_sq[k] <= r_u[k] * r_u[k];
        end
        r_u5  <= r_u;
        r_sd5 <= r_sd4;

        r_sum <= rmq_pkg::SW'(r_sq[0]) + rmq_pkg::SW'(r_sq[1])
               + rmq_pkg::SW'(r_sq[2]) + rmq_pkg::SW'(r_sq[3]);
        r_tag6.u   <= r_u5;
        r_tag6.neg <= r_sd5.neg;
        r_tag6.deg <= r_sd5.deg;
    end

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[6]),
        .i_sum   (r_sum),
        .i_tag   (r_tag6),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_num[k] <= (NW'(sq_tag.u[k]) << 30) + NW'(sq_root >> 1);
        end
        r_den     <= sq_root;
        r_psd.neg <= sq_tag.neg;
        r_psd.deg <= sq_tag.deg;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        rmq_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_pvld),
            .i_num   (r_num[k]),
            .i_den   (r_den),
            .o_vld   (dv_vld[k]),
            .o_quo   (dv_quo[k])
        );
    end

    assign r_dsd[0] = r_psd;
    for (genvar s = 0; s < rmq_pkg::DIV_STAGES; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            r_dsd[s+1] <= r_dsd[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= dv_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW-1:0] q [4];
        rmq_pkg::t_side sd;
        sd = r_dsd[rmq_pkg::DIV_STAGES];
        for (int k = 0; k < 4; k++) begin
            q[k] = (sd.neg[k] ^ sd.neg[0]) ? -DW'(dv_quo[k]) : DW'(dv_quo[k]);
        end
        if (sd.deg) begin
            o_res.qw <= rmq_pkg::ONE_Q30;
            o_res.qx <= '0;
            o_res.qy <= '0;
            o_res.qz <= '0;
        end else begin
            o_res.qw <= dv_quo[0];
            o_res.qx <= q[1];
            o_res.qy <= q[2];
            o_res.qz <= q[3];
        end
        o_res.degenerate <= sd.deg;
    end

    assign o_valid = r_ovld;

    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.degenerate |->
            o_res.qw == rmq_pkg::ONE_Q30 && o_res.qx == 0 && o_res.qy == 0 && o_res.qz == 0)
        else $error("degenerate result is not the identity");

    a_norm_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !r_sd4.deg |->
            (r_u[0][QW-1] || r_u[1][QW-1] || r_u[2][QW-1] || r_u[3][QW-1]))
        else $error("normalising shift left no leading one");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_vld && !sq_tag.deg |-> sq_root[DW-1:DW-2] != 2'b00)
        else $error("root of normalised sum below one");

endmodule

/* hdl/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a carried tag.
module rmq_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [rmq_pkg::SW-1:0]      i_sum,
    input  rmq_pkg::t_tag               i_tag,
    output logic                        o_vld,
    output logic [rmq_pkg::DW-1:0]      o_root,
    output rmq_pkg::t_tag               o_tag
);

    logic [rmq_pkg::SW-1:0] r_x   [0:rmq_pkg::SQRT_STAGES];
    logic [rmq_pkg::SW-1:0] r_res [0:rmq_pkg::SQRT_STAGES];
    rmq_pkg::t_tag          r_tag [0:rmq_pkg::SQRT_STAGES];
    logic [rmq_pkg::SQRT_STAGES:0] r_vld;

    assign r_x[0]   = i_sum;
    assign r_res[0] = '0;
    assign r_tag[0] = i_tag;
    assign r_vld[0] = i_vld;

    for (genvar i = 0; i < rmq_pkg::SQRT_STAGES; i++) begin : g_stage
        localparam logic [rmq_pkg::SW-1:0] BIT = rmq_pkg::SW'(1) << (62 - 2 * i);
        logic [rmq_pkg::SW-1:0] n_x;
        logic [rmq_pkg::SW-1:0] n_res;
        logic [rmq_pkg::SW-1:0] trial;

        always_comb begin
            trial = r_res[i] + BIT;
            if (r_x[i] >= trial) begin
                n_x   = r_x[i] - trial;
                n_res = (r_res[i] >> 1) + BIT;
            end else begin
                n_x   = r_x[i];
                n_res = r_res[i] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1]   <= n_x;
            r_res[i+1] <= n_res;
            r_tag[i+1] <= r_tag[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    assign o_vld  = r_vld[rmq_pkg::SQRT_STAGES];
    assign o_root = r_res[rmq_pkg::SQRT_STAGES][rmq_pkg::DW-1:0];
    assign o_tag  = r_tag[rmq_pkg::SQRT_STAGES];

endmodule

/* hdl/rmq_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module rmq_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic [rmq_pkg::NW-1:0] i_num,
    input  logic [rmq_pkg::DW-1:0] i_den,
    output logic                   o_vld,
    output logic [rmq_pkg::QW-1:0] o_quo
);

    localparam int ST = rmq_pkg::DIV_STAGES;

    logic [rmq_pkg::DW-1:0] r_rem [0:ST];
    logic [rmq_pkg::QW-1:0] r_low [0:ST];
    logic [rmq_pkg::QW-1:0] r_quo [0:ST];
    logic [rmq_pkg::DW-1:0] r_den [0:ST];
    logic [ST:0]            r_vld;

    assign r_rem[0] = rmq_pkg::DW'(i_num[rmq_pkg::NW-1:rmq_pkg::QW]);
    assign r_low[0] = i_num[rmq_pkg::QW-1:0];
    assign r_quo[0] = '0;
    assign r_den[0] = i_den;
    assign r_vld[0] = i_vld;

    for (genvar k = 0; k < ST; k++) begin : g_stage
        logic [rmq_pkg::DW:0]   trial;
        logic [rmq_pkg::DW:0]   diff;
        logic                   take;
        logic [rmq_pkg::DW-1:0] n_rem;

        always_comb begin
            trial = {r_rem[k], r_low[k][ST-1-k]};
            diff  = trial - {1'b0, r_den[k]};
            take  = trial >= {1'b0, r_den[k]};
            n_rem = take ? diff[rmq_pkg::DW-1:0] : trial[rmq_pkg::DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_low[k+1] <= r_low[k];
            r_quo[k+1] <= {r_quo[k][rmq_pkg::QW-2:0], take};
            r_den[k+1] <= r_den[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    assign o_vld = r_vld[ST];
    assign o_quo = r_quo[ST];

endmodule

/* tb/rotation_matrix_to_quaternion_tb.sv */
// Testbench for the matrix-to-quaternion block: predicts each result and checks it in order.
module rotation_matrix_to_quaternion_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = rmq_pkg::DW;
    localparam int QW = rmq_pkg::QW;
    localparam int LATENCY = 72;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1250;
    localparam logic signed [DW-1:0] Q_ONE = 32'sh4000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rmq_pkg::t_in i_in = '0;
    logic o_valid;
    rmq_pkg::t_out o_res;

    rmq_pkg::t_in matrix_q[$];
    rmq_pkg::t_out quat_expected_q[$];
    int sender_idle_pct = 16;
    bit hold_sender = 1'b0;
    bit stimulus_done = 1'b0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res, bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic rmq_pkg::t_out matrix_to_quat(input rmq_pkg::t_in m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
        longint v[4];
        longint q[4];
        logic [63:0] mag[4];
        logic [63:0] big, total, nrm;
        int len;
        rmq_pkg::t_out o;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        tr = a00 + a11 + a22;
        if (tr > 0) begin
            rad = 64'sd1073741824 + tr;
            v[0] = rad; v[1] = a21 - a12; v[2] = a02 - a20; v[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            rad = 64'sd1073741824 + a00 - a11 - a22;
            v[0] = a21 - a12; v[1] = rad; v[2] = a01 + a10; v[3] = a02 + a20;
        end else if (a11 > a22) begin
            rad = 64'sd1073741824 + a11 - a00 - a22;
            v[0] = a02 - a20; v[1] = a01 + a10; v[2] = rad; v[3] = a12 + a21;
        end else begin
            rad = 64'sd1073741824 + a22 - a00 - a11;
            v[0] = a10 - a01; v[1] = a02 + a20; v[2] = a12 + a21; v[3] = rad;
        end
        o = '0;
        if (rad <= 0) begin
            o.qw = rmq_pkg::ONE_Q30;
            o.degenerate = 1'b1;
            return o;
        end
        big = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > big) big = mag[i];
        end
        len = 0;
        for (int k = 0; k < 64; k++) if (big[k]) len = k + 1;
        total = 0;
        for (int i = 0; i < 4; i++) begin
            if (len > 31) mag[i] >>= (len - 31);
            else mag[i] <<= (31 - len);
            total += mag[i] * mag[i];
        end
        nrm = root_floor(total);
        if (nrm == 0) nrm = 1;
        for (int i = 0; i < 4; i++) begin
            q[i] = ((mag[i] << 30) + (nrm >> 1)) / nrm;
            if (v[i] < 0) q[i] = -q[i];
            if (v[0] < 0) q[i] = -q[i];
        end
        o.qw = q[0][QW-1:0];
        o.qx = q[1][DW-1:0];
        o.qy = q[2][DW-1:0];
        o.qz = q[3][DW-1:0];
        return o;
    endfunction

    function automatic logic signed [DW-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3, 4: return $signed($urandom());
            default: return $signed(32'($urandom_range(0, 32'h8000_0000))) - (Q_ONE >>> 1);
        endcase
    endfunction

    function automatic rmq_pkg::t_in random_matrix();
        rmq_pkg::t_in m;
        real ang, c, s;
        int ax;
        if ($urandom_range(0, 3) == 0) begin
            m.m00 = pick_entry(); m.m01 = pick_entry(); m.m02 = pick_entry();
            m.m10 = pick_entry(); m.m11 = pick_entry(); m.m12 = pick_entry();
            m.m20 = pick_entry(); m.m21 = pick_entry(); m.m22 = pick_entry();
            return m;
        end
        // rotation about one axis, with small integer jitter
        ang = ($urandom() % 100000) * 6.2831853 / 100000.0;
        c = $cos(ang) * 1073741824.0;
        s = $sin(ang) * 1073741824.0;
        ax = $urandom_range(0, 2);
        m = '0;
        case (ax)
            0: begin
                m.m00 = Q_ONE; m.m11 = int'(c); m.m22 = int'(c);
                m.m12 = -int'(s); m.m21 = int'(s);
            end
            1: begin
                m.m11 = Q_ONE; m.m00 = int'(c); m.m22 = int'(c);
                m.m02 = int'(s); m.m20 = -int'(s);
            end
            default: begin
                m.m22 = Q_ONE; m.m00 = int'(c); m.m11 = int'(c);
                m.m01 = -int'(s); m.m10 = int'(s);
            end
        endcase
        m.m01 += $signed(32'($urandom_range(0, 15))) - 8;
        m.m20 += $signed(32'($urandom_range(0, 15))) - 8;
        return m;
    endfunction

    function automatic rmq_pkg::t_in diag_matrix(input logic signed [DW-1:0] d0, d1, d2);
        rmq_pkg::t_in m;
        m = '0;
        m.m00 = d0; m.m11 = d1; m.m22 = d2;
        return m;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sender) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (matrix_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            i_in <= matrix_q.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
        if (i_rst_n && start && !busy)
            quat_expected_q.insert(quat_expected_q.size(), matrix_to_quat(i_in));
    end

    // monitor
    always @(posedge i_clk) begin
        rmq_pkg::t_out exp_q;
        if (i_rst_n && o_valid) begin
            if (quat_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", o_res);
            end else begin
                exp_q = quat_expected_q.pop_front();
                if (o_res.qw !== exp_q.qw || o_res.qx !== exp_q.qx
                    || o_res.qy !== exp_q.qy || o_res.qz !== exp_q.qz
                    || o_res.degenerate !== exp_q.degenerate) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected w=%h x=%h y=%h z=%h d=%b,",
                                  " got w=%h x=%h y=%h z=%h d=%b"},
                            exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degenerate,
                            o_res.qw, o_res.qx, o_res.qy, o_res.qz, o_res.degenerate);
                end
            end
        end
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        rmq_pkg::t_in m;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // identity, half turns, zero and extreme entries
        matrix_q.insert(matrix_q.size(), diag_matrix(Q_ONE, Q_ONE, Q_ONE));
        matrix_q.insert(matrix_q.size(), diag_matrix(Q_ONE, -Q_ONE, -Q_ONE));
        matrix_q.insert(matrix_q.size(), diag_matrix(-Q_ONE, Q_ONE, -Q_ONE));
        matrix_q.insert(matrix_q.size(), diag_matrix(-Q_ONE, -Q_ONE, Q_ONE));
        matrix_q.insert(matrix_q.size(), diag_matrix(-Q_ONE, -Q_ONE, -Q_ONE));
        matrix_q.insert(matrix_q.size(), diag_matrix(0, 0, 0));
        matrix_q.insert(matrix_q.size(), diag_matrix(-Q_ONE, -Q_ONE, -Q_ONE - Q_ONE));
        matrix_q.insert(matrix_q.size(),
            diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        matrix_q.insert(matrix_q.size(),
            diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        matrix_q.insert(matrix_q.size(), diag_matrix(-Q_ONE, -Q_ONE, -Q_ONE + 1));
        m = '1;
        matrix_q.insert(matrix_q.size(), m);
        m = '0; m.m01 = 32'sh8000_0000; m.m10 = 32'sh7fff_ffff; m.m21 = 32'sh8000_0000;
        m.m12 = 32'sh7fff_ffff; m.m02 = 32'sh8000_0000; m.m20 = 32'sh7fff_ffff;
        matrix_q.insert(matrix_q.size(), m);
        m = {9{32'sh8000_0000}};
        matrix_q.insert(matrix_q.size(), m);
        m = {9{32'sh7fff_ffff}};
        matrix_q.insert(matrix_q.size(), m);
        m = diag_matrix(0, 0, 0); m.m12 = Q_ONE; m.m21 = -Q_ONE;
        matrix_q.insert(matrix_q.size(), m);
        m = diag_matrix(5, 5, -20); m.m01 = -Q_ONE;
        matrix_q.insert(matrix_q.size(), m);
        for (int k = 0; k < N_RANDOM; k++) matrix_q.insert(matrix_q.size(), random_matrix());
        wait (matrix_q.size() < N_RANDOM * 2 / 3);
        hold_sender = 1'b1;
        wait (quat_expected_q.size() == 0);
        @(posedge i_clk);
        hold_sender = 1'b0;
        sender_idle_pct = 75;
        wait (matrix_q.size() < N_RANDOM / 3);
        sender_idle_pct = 0;
        wait (matrix_q.size() == 0);
        @(posedge i_clk);
        @(posedge i_clk);
        wait (quat_expected_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && quat_expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* sim.f */
hdl/rmq_pkg.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
